FILE: rtl/gisc_pkg.sv
// ----------------------------------------------------------------------------
// gisc_pkg
// Shared constants, codes and types of the grouped interrupt status
// controller: group and line geometry, item codes, FSM state and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gisc_pkg;

   // Geometry
   localparam int NUM_GROUPS = 10;
   localparam int LINES      = 32;
   localparam int MULTI_OUTS = 10;

   localparam int DATA_W    = 32;
   localparam int GROUP_W   = 4;
   localparam int IRQ_W     = 19;
   localparam int GIDX_W    = $clog2(NUM_GROUPS);
   localparam int WIDE_CNT  = (MULTI_OUTS < DATA_W) ? MULTI_OUTS : DATA_W;
   localparam int OUT_LINES = MULTI_OUTS + NUM_GROUPS - 1;

   localparam logic [DATA_W-1:0] ALL_ONES  = 32'hffff_ffff;
   localparam logic [DATA_W-1:0] LINE_MASK = DATA_W'((64'd1 << LINES) - 64'd1);
   localparam logic [DATA_W-1:0] WIDE_MASK = DATA_W'((64'd1 << WIDE_CNT) - 64'd1);
   localparam logic [GROUP_W:0]  GROUP_LIMIT = (GROUP_W + 1)'(NUM_GROUPS);

   // Item modes
   localparam logic [1:0] MODE_EVENT = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;
   localparam logic [1:0] MODE_NONE  = 2'd3;

   // Register kinds
   localparam logic KIND_ENABLE = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BAD_GROUP  = 2'd1;
   localparam logic [1:0] ST_ZERO_WRITE = 2'd2;

   typedef enum logic {
      CTL_IDLE,
      CTL_EXEC
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_status_type;

endpackage

FILE: rtl/gisc_ctrl.sv
// ----------------------------------------------------------------------------
// gisc_ctrl
// Controller: takes one request word, then holds the execute state until
// the response register is free and commits the group update there.
// ----------------------------------------------------------------------------
module gisc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  gisc_pkg::dp_status_type dp_status,
   output gisc_pkg::ctl_cmd_type   ctl_cmd
);

   gisc_pkg::ctl_state_type state_ff, state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gisc_pkg::CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gisc_pkg::CTL_IDLE: begin
            if (req_valid) begin
               state_in = gisc_pkg::CTL_EXEC;
            end
         end
         gisc_pkg::CTL_EXEC: begin
            if (!dp_status.out_busy) begin
               state_in = gisc_pkg::CTL_IDLE;
            end
         end
         default: begin
            state_in = gisc_pkg::CTL_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_stall      = 1'b1;
      ctl_cmd.capture = 1'b0;
      ctl_cmd.commit  = 1'b0;
      case (state_ff)
         gisc_pkg::CTL_IDLE: begin
            req_stall       = 1'b0;
            ctl_cmd.capture = req_valid;
         end
         gisc_pkg::CTL_EXEC: begin
            ctl_cmd.commit = !dp_status.out_busy;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

FILE: rtl/gisc_datapath.sv
// ----------------------------------------------------------------------------
// gisc_datapath
// Datapath: request word register, per-group register file, output line
// register, read-modify-write of one group and the response register.
// ----------------------------------------------------------------------------
module gisc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  gisc_pkg::ctl_cmd_type             ctl_cmd,
   output gisc_pkg::dp_status_type           dp_status,
   input  logic [1:0]                        req_mode,
   input  logic [gisc_pkg::GROUP_W-1:0]      req_group,
   input  logic                              req_reg_kind,
   input  logic                              req_source_level,
   input  logic [gisc_pkg::DATA_W-1:0]       req_line_levels,
   input  logic [gisc_pkg::DATA_W-1:0]       req_write_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gisc_pkg::IRQ_W-1:0]        rsp_irq_out,
   output logic [gisc_pkg::DATA_W-1:0]       rsp_read_data,
   output logic [1:0]                        rsp_status
);

   localparam int NG = gisc_pkg::NUM_GROUPS;
   localparam int DW = gisc_pkg::DATA_W;
   localparam int GW = gisc_pkg::GIDX_W;
   localparam int OL = gisc_pkg::OUT_LINES;

   // Captured request word
   logic [1:0]                   mode_ff;
   logic [gisc_pkg::GROUP_W-1:0] group_ff;
   logic                         kind_ff;
   logic                         level_ff;
   logic [DW-1:0]                levels_ff;
   logic [DW-1:0]                wdata_ff;

   // Group register file
   logic [DW-1:0] ena_acc_ff [NG];
   logic [DW-1:0] ena_reg_ff [NG];
   logic [DW-1:0] stat_ff    [NG];
   logic [DW-1:0] mask_ff    [NG];
   logic [DW-1:0] pend_ff    [NG];
   logic [OL-1:0] lines_ff, lines_in;

   // Response register
   logic                              rsp_valid_ff;
   logic [gisc_pkg::IRQ_W-1:0]        irq_ff, irq_in;
   logic [DW-1:0]                     rdata_ff, rdata_in;
   logic [1:0]                        rstat_ff, rstat_in;

   logic          grp_ok;
   logic [GW-1:0] gidx;
   logic [DW-1:0] ea, er, sr, mb, pb;
   logic [DW-1:0] ea_in, er_in, sr_in, mb_in, pb_in;
   logic [OL-1:0] grp_line;

   assign grp_ok = {1'b0, group_ff} < gisc_pkg::GROUP_LIMIT;
   assign gidx   = group_ff[GW-1:0];

   assign dp_status.out_busy = rsp_valid_ff && rsp_stall;

   // Read the addressed group
   always_comb begin
      ea = '0;
      er = '0;
      sr = '0;
      mb = '0;
      pb = '0;
      if (grp_ok) begin
         ea = ena_acc_ff[gidx];
         er = ena_reg_ff[gidx];
         sr = stat_ff[gidx];
         mb = mask_ff[gidx];
         pb = pend_ff[gidx];
      end
   end

   // Decode the single output line of a narrow group
   always_comb begin
      grp_line = '0;
      for (int j = 1; j < NG; j++) begin
         grp_line[gisc_pkg::MULTI_OUTS + j - 1] = (gidx == GW'(j));
      end
   end

   // Update the group and build the response
   always_comb begin
      logic [DW-1:0] sel;
      logic [DW-1:0] wsel;
      logic [DW-1:0] blocked;
      logic [DW-1:0] fresh;
      logic [DW-1:0] change;
      logic [DW-1:0] sr_clr;
      logic [DW-1:0] wdat;
      logic [DW-1:0] replay;
      logic          is_wide;

      ea_in    = ea;
      er_in    = er;
      sr_in    = sr;
      mb_in    = mb;
      pb_in    = pb;
      lines_in = lines_ff;
      rdata_in = '0;
      rstat_in = gisc_pkg::ST_OK;
      is_wide  = (group_ff == '0);

      sel     = levels_ff & ea & gisc_pkg::LINE_MASK;
      wsel    = sel & gisc_pkg::WIDE_MASK;
      blocked = wsel & (mb | sr);
      fresh   = wsel & ~(mb | sr);
      change  = er ^ wdata_ff;
      sr_clr  = sr & ~wdata_ff;
      wdat    = wdata_ff & gisc_pkg::WIDE_MASK;
      replay  = wdat & pb;

      if (mode_ff != gisc_pkg::MODE_NONE && !grp_ok) begin
         rstat_in = gisc_pkg::ST_BAD_GROUP;
      end else begin
         case (mode_ff)
            gisc_pkg::MODE_EVENT: begin
               // Latch selected sources as status or pending
               if (level_ff && sel != '0) begin
                  if (is_wide) begin
                     pb_in = pb | blocked;
                     sr_in = sr | fresh;
                     for (int i = 0; i < gisc_pkg::WIDE_CNT; i++) begin
                        if (fresh[i]) begin
                           lines_in[i] = 1'b1;
                        end
                     end
                  end else if (mb != '0 || sr != '0) begin
                     pb_in = pb | sel;
                  end else begin
                     sr_in    = sel;
                     lines_in = lines_ff | grp_line;
                  end
               end
            end
            gisc_pkg::MODE_WRITE: begin
               if (kind_ff == gisc_pkg::KIND_ENABLE) begin
                  // Add enables, or mask and unmask by toggled bits
                  if (wdata_ff == '0 && ea == '0) begin
                     er_in = '0;
                  end else if ((ea | wdata_ff) != ea) begin
                     ea_in = ea | wdata_ff;
                     er_in = wdata_ff;
                  end else begin
                     if ((change & wdata_ff) != '0) begin
                        mb_in = mb & ~change;
                     end else begin
                        mb_in = mb | change;
                     end
                     er_in = wdata_ff;
                  end
               end else if (wdata_ff == '0) begin
                  rstat_in = gisc_pkg::ST_ZERO_WRITE;
               end else begin
                  // Clear status, then replay pending or drop lines
                  sr_in = sr_clr;
                  if (wdata_ff != gisc_pkg::ALL_ONES) begin
                     if (is_wide) begin
                        sr_in = sr_clr | replay;
                        pb_in = pb & ~replay;
                        for (int i = 0; i < gisc_pkg::WIDE_CNT; i++) begin
                           if (wdat[i]) begin
                              lines_in[i] = replay[i];
                           end
                        end
                     end else if (sr_clr == '0) begin
                        if (pb != '0) begin
                           sr_in    = pb;
                           pb_in    = '0;
                           lines_in = lines_ff | grp_line;
                        end else begin
                           lines_in = lines_ff & ~grp_line;
                        end
                     end
                  end
               end
            end
            gisc_pkg::MODE_READ: begin
               rdata_in = (kind_ff == gisc_pkg::KIND_STATUS) ? sr : er;
            end
            default: begin
               rdata_in = '0;
            end
         endcase
      end

      irq_in = '0;
      for (int i = 0; i < gisc_pkg::IRQ_W; i++) begin
         if (i < OL) begin
            irq_in[i] = lines_in[i];
         end
      end
   end

   // Capture the request word
   always_ff @(posedge clock) begin
      if (ctl_cmd.capture) begin
         mode_ff   <= req_mode;
         group_ff  <= req_group;
         kind_ff   <= req_reg_kind;
         level_ff  <= req_source_level;
         levels_ff <= req_line_levels;
         wdata_ff  <= req_write_data;
      end
   end

   // Write back the group and output lines
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < NG; g++) begin
            ena_acc_ff[g] <= '0;
            ena_reg_ff[g] <= '0;
            stat_ff[g]    <= '0;
            mask_ff[g]    <= '0;
            pend_ff[g]    <= '0;
         end
         lines_ff <= '0;
      end else if (ctl_cmd.commit) begin
         if (grp_ok) begin
            ena_acc_ff[gidx] <= ea_in;
            ena_reg_ff[gidx] <= er_in;
            stat_ff[gidx]    <= sr_in;
            mask_ff[gidx]    <= mb_in;
            pend_ff[gidx]    <= pb_in;
         end
         lines_ff <= lines_in;
      end
   end

   // Load and drain the response word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl_cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.commit) begin
         irq_ff   <= irq_in;
         rdata_ff <= rdata_in;
         rstat_ff <= rstat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_irq_out   = irq_ff;
   assign rsp_read_data = rdata_ff;
   assign rsp_status    = rstat_ff;

endmodule

FILE: rtl/grouped_interrupt_status_controller_unit.sv
// ----------------------------------------------------------------------------
// grouped_interrupt_status_controller_unit
// Each accepted request word is captured, then one read-modify-write on the
//   addressed group's registers runs in the execute state and loads the
//   response register. No new word is taken until the execute state ends.
// A stalled response holds the execute state until the response register
//   frees. Synchronous active-high reset clears all group registers and
//   output lines at once.
// ----------------------------------------------------------------------------
module grouped_interrupt_status_controller_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_mode,
   input  logic [gisc_pkg::GROUP_W-1:0]      req_group,
   input  logic                              req_reg_kind,
   input  logic                              req_source_level,
   input  logic [gisc_pkg::DATA_W-1:0]       req_line_levels,
   input  logic [gisc_pkg::DATA_W-1:0]       req_write_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gisc_pkg::IRQ_W-1:0]        rsp_irq_out,
   output logic [gisc_pkg::DATA_W-1:0]       rsp_read_data,
   output logic [1:0]                        rsp_status
);

   gisc_pkg::ctl_cmd_type   ctl_cmd;
   gisc_pkg::dp_status_type dp_status;

   // Sequence one word at a time
   gisc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .ctl_cmd   (ctl_cmd)
   );

   // Group registers and response
   gisc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl_cmd          (ctl_cmd),
      .dp_status        (dp_status),
      .req_mode         (req_mode),
      .req_group        (req_group),
      .req_reg_kind     (req_reg_kind),
      .req_source_level (req_source_level),
      .req_line_levels  (req_line_levels),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_irq_out      (rsp_irq_out),
      .rsp_read_data    (rsp_read_data),
      .rsp_status       (rsp_status)
   );

endmodule

FILE: sim/grouped_interrupt_status_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// grouped_interrupt_status_controller_unit_tb
// Drives source events, enable and status writes and register reads into the
// interrupt controller. A behavioral copy of the group registers predicts
// every response word, and each response is checked field by field in order.
// Covers directed corner cases, random arm/fire/clear flows with noise, a
// long response hold-off, a drain pause and a stretch with no idling.
// ----------------------------------------------------------------------------
module grouped_interrupt_status_controller_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_W     = gisc_pkg::DATA_W;
   localparam int GROUP_W    = gisc_pkg::GROUP_W;
   localparam int IRQ_W      = gisc_pkg::IRQ_W;
   localparam int NUM_GROUPS = gisc_pkg::NUM_GROUPS;
   localparam int WIDE_CNT   = gisc_pkg::WIDE_CNT;
   localparam int MULTI_OUTS = gisc_pkg::MULTI_OUTS;

   localparam int HOLD_CYCLES = 200;
   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = 10;

   typedef struct {
      logic [1:0]         mode;
      logic [GROUP_W-1:0] grp;
      logic               kind;
      logic               level;
      logic [DATA_W-1:0]  levels;
      logic [DATA_W-1:0]  data;
   } irq_word_type;

   typedef struct {
      logic [IRQ_W-1:0]  irq;
      logic [DATA_W-1:0] rdata;
      logic [1:0]        code;
   } irq_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic [1:0]         req_mode         = gisc_pkg::MODE_NONE;
   logic [GROUP_W-1:0] req_group        = '0;
   logic               req_reg_kind     = gisc_pkg::KIND_ENABLE;
   logic               req_source_level = 1'b0;
   logic [DATA_W-1:0]  req_line_levels  = '0;
   logic [DATA_W-1:0]  req_write_data   = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic [IRQ_W-1:0]   rsp_irq_out;
   logic [DATA_W-1:0]  rsp_read_data;
   logic [1:0]         rsp_status;

   // predicted group registers
   logic [DATA_W-1:0] grp_enable_sum  [NUM_GROUPS];
   logic [DATA_W-1:0] grp_enable_last [NUM_GROUPS];
   logic [DATA_W-1:0] grp_status      [NUM_GROUPS];
   logic [DATA_W-1:0] grp_mask        [NUM_GROUPS];
   logic [DATA_W-1:0] grp_pending     [NUM_GROUPS];
   logic [IRQ_W-1:0]  irq_lines;

   irq_rsp_type awaited_rsp_q[$];
   int       mismatches  = 0;
   int       quiet_count = 0;
   int       hold_left   = 0;
   bit       hold_ask    = 1'b0;
   bit       req_gaps_on = 1'b1;
   bit       rsp_gaps_on = 1'b1;

   grouped_interrupt_status_controller_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_group        (req_group),
      .req_reg_kind     (req_reg_kind),
      .req_source_level (req_source_level),
      .req_line_levels  (req_line_levels),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_irq_out      (rsp_irq_out),
      .rsp_read_data    (rsp_read_data),
      .rsp_status       (rsp_status)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // Group register predictor
   // --------------------------------------------------------------------------

   // Select enabled high lines; hold them pending while masked or busy.
   function automatic void fire_sources(int g, logic [DATA_W-1:0] lv);
      logic [DATA_W-1:0] sel;
      sel = lv & grp_enable_sum[g] & gisc_pkg::LINE_MASK;
      if (sel == '0) return;
      if (g == 0) begin
         for (int i = 0; i < WIDE_CNT; i++) begin
            if (sel[i]) begin
               if (grp_mask[0][i] || grp_status[0][i]) begin
                  grp_pending[0][i] = 1'b1;
               end else begin
                  grp_status[0][i] = 1'b1;
                  irq_lines[i]     = 1'b1;
               end
            end
         end
      end else if (grp_mask[g] != '0 || grp_status[g] != '0) begin
         grp_pending[g] |= sel;
      end else begin
         grp_status[g]                = sel;
         irq_lines[MULTI_OUTS + g - 1] = 1'b1;
      end
   endfunction

   // Grow the enables, or mask and unmask by the toggled bits once they stop growing.
   function automatic void write_enables(int g, logic [DATA_W-1:0] d);
      logic [DATA_W-1:0] prev;
      logic [DATA_W-1:0] flip;
      if (d == '0 && grp_enable_sum[g] == '0) begin
         grp_enable_last[g] = '0;
         return;
      end
      prev = grp_enable_sum[g];
      grp_enable_sum[g] |= d;
      if (prev != grp_enable_sum[g]) begin
         grp_enable_last[g] = d;
         return;
      end
      flip = grp_enable_last[g] ^ d;
      if ((flip & d) != '0) grp_mask[g] &= ~flip;
      else grp_mask[g] |= flip;
      grp_enable_last[g] = d;
   endfunction

   // Clear status bits, then replay pending sources or drop the outputs.
   function automatic void clear_status(int g, logic [DATA_W-1:0] d);
      grp_status[g] &= ~d;
      if (d == gisc_pkg::ALL_ONES) return;
      if (g == 0) begin
         for (int i = 0; i < WIDE_CNT; i++) begin
            if (d[i]) begin
               if (grp_pending[0][i]) begin
                  grp_status[0][i]  = 1'b1;
                  grp_pending[0][i] = 1'b0;
                  irq_lines[i]      = 1'b1;
               end else begin
                  irq_lines[i] = 1'b0;
               end
            end
         end
      end else if (grp_status[g] == '0) begin
         if (grp_pending[g] != '0) begin
            grp_status[g]                 = grp_pending[g];
            grp_pending[g]                = '0;
            irq_lines[MULTI_OUTS + g - 1] = 1'b1;
         end else begin
            irq_lines[MULTI_OUTS + g - 1] = 1'b0;
         end
      end
   endfunction

   function automatic irq_rsp_type predict_irq_response(irq_word_type w);
      irq_rsp_type r;
      int          g;
      g       = int'(w.grp);
      r.rdata = '0;
      r.code  = gisc_pkg::ST_OK;
      if (w.mode != gisc_pkg::MODE_NONE && g >= NUM_GROUPS) begin
         r.code = gisc_pkg::ST_BAD_GROUP;
      end else if (w.mode == gisc_pkg::MODE_EVENT) begin
         if (w.level) fire_sources(g, w.levels);
      end else if (w.mode == gisc_pkg::MODE_WRITE) begin
         if (w.kind == gisc_pkg::KIND_ENABLE) write_enables(g, w.data);
         else if (w.data == '0) r.code = gisc_pkg::ST_ZERO_WRITE;
         else clear_status(g, w.data);
      end else if (w.mode == gisc_pkg::MODE_READ) begin
         r.rdata = (w.kind == gisc_pkg::KIND_STATUS) ? grp_status[g] : grp_enable_last[g];
      end
      r.irq = irq_lines;
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // Request side
   // --------------------------------------------------------------------------

   // Offer one word, hold it until accepted, then log its expected response.
   task automatic send_word(input logic [1:0] mode, input int g, input logic kind,
                            input logic level, input logic [DATA_W-1:0] levels,
                            input logic [DATA_W-1:0] data);
      irq_word_type w;
      w.mode   = mode;
      w.grp    = GROUP_W'(g);
      w.kind   = kind;
      w.level  = level;
      w.levels = levels;
      w.data   = data;
      if (req_gaps_on && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= w.mode;
      req_group        <= w.grp;
      req_reg_kind     <= w.kind;
      req_source_level <= w.level;
      req_line_levels  <= w.levels;
      req_write_data   <= w.data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      awaited_rsp_q.push_back(predict_irq_response(w));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (awaited_rsp_q.size() != 0) @(posedge clock);
   endtask

   // Fully random word: invalid groups, mode three, ignored events and all.
   task automatic send_noise();
      send_word(2'($urandom_range(3, 0)), $urandom_range(15, 0), 1'($urandom_range(1, 0)),
                1'($urandom_range(1, 0)), $urandom, $urandom);
   endtask

   function automatic logic [DATA_W-1:0] pick_enable(int g);
      case ($urandom_range(5, 0))
         0:       return grp_enable_last[g] ^ (32'h1 << $urandom_range(31, 0));
         1:       return grp_enable_last[g] ^ (32'h1 << $urandom_range(31, 0));
         2:       return grp_enable_last[g];
         3:       return gisc_pkg::ALL_ONES;
         4:       return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_clear(int g);
      case ($urandom_range(5, 0))
         0:       return grp_status[g];
         1:       return grp_status[g];
         2:       return 32'h1 << $urandom_range(31, 0);
         3:       return gisc_pkg::ALL_ONES;
         4:       return grp_status[g] | (32'h1 << $urandom_range(31, 0));
         default: return $urandom;
      endcase
   endfunction

   // One arm, fire, clear and read-back flow on a random valid group.
   task automatic send_flow();
      int g;
      g = $urandom_range(NUM_GROUPS - 1, 0);
      send_word(gisc_pkg::MODE_WRITE, g, gisc_pkg::KIND_ENABLE, 1'($urandom_range(1, 0)),
                $urandom, pick_enable(g));
      repeat ($urandom_range(3, 1)) begin
         send_word(gisc_pkg::MODE_EVENT, g, 1'($urandom_range(1, 0)),
                   $urandom_range(99) < 90, $urandom, $urandom);
      end
      send_word(gisc_pkg::MODE_WRITE, g, gisc_pkg::KIND_STATUS, 1'($urandom_range(1, 0)),
                $urandom, pick_clear(g));
      send_word(gisc_pkg::MODE_READ, g, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                $urandom, $urandom);
   endtask

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------

   task automatic test_directed_cases();
      // reset values, no enables yet, enable write of zero from nothing
      send_word(gisc_pkg::MODE_READ,  0, gisc_pkg::KIND_ENABLE, 1'b0, '0, '0);
      send_word(gisc_pkg::MODE_READ,  9, gisc_pkg::KIND_STATUS, 1'b0, '0, '0);
      send_word(gisc_pkg::MODE_EVENT, 0, gisc_pkg::KIND_ENABLE, 1'b1, gisc_pkg::ALL_ONES, '0);
      send_word(gisc_pkg::MODE_WRITE, 5, gisc_pkg::KIND_ENABLE, 1'b0, '0, '0);
      // wide group: ignored event, fire, second fire goes pending
      send_word(gisc_pkg::MODE_WRITE, 0, gisc_pkg::KIND_ENABLE, 1'b0, '0, gisc_pkg::ALL_ONES);
      send_word(gisc_pkg::MODE_EVENT, 0, gisc_pkg::KIND_ENABLE, 1'b0, gisc_pkg::ALL_ONES, '0);
      send_word(gisc_pkg::MODE_EVENT, 0, gisc_pkg::KIND_ENABLE, 1'b1, gisc_pkg::ALL_ONES, '0);
      send_word(gisc_pkg::MODE_EVENT, 0, gisc_pkg::KIND_ENABLE, 1'b1, gisc_pkg::ALL_ONES, '0);
      // zero status write, replay, bit above the wide outputs, full clear
      send_word(gisc_pkg::MODE_WRITE, 0, gisc_pkg::KIND_STATUS, 1'b0, '0, '0);
      send_word(gisc_pkg::MODE_WRITE, 0, gisc_pkg::KIND_STATUS, 1'b0, '0, 32'h0000_0001);
      send_word(gisc_pkg::MODE_WRITE, 0, gisc_pkg::KIND_STATUS, 1'b0, '0, 32'h0000_0402);
      send_word(gisc_pkg::MODE_WRITE, 0, gisc_pkg::KIND_STATUS, 1'b0, '0, gisc_pkg::ALL_ONES);
      // mask by toggled enables, fire while masked, unmask, replay
      send_word(gisc_pkg::MODE_WRITE, 0, gisc_pkg::KIND_ENABLE, 1'b0, '0, 32'hffff_fff0);
      send_word(gisc_pkg::MODE_EVENT, 0, gisc_pkg::KIND_ENABLE, 1'b1, 32'h0000_000f, '0);
      send_word(gisc_pkg::MODE_WRITE, 0, gisc_pkg::KIND_ENABLE, 1'b0, '0, gisc_pkg::ALL_ONES);
      send_word(gisc_pkg::MODE_WRITE, 0, gisc_pkg::KIND_STATUS, 1'b0, '0, 32'h0000_000f);
      // last single-line group: fire, pend, replay, drop
      send_word(gisc_pkg::MODE_WRITE, 9, gisc_pkg::KIND_ENABLE, 1'b0, '0, gisc_pkg::ALL_ONES);
      send_word(gisc_pkg::MODE_EVENT, 9, gisc_pkg::KIND_ENABLE, 1'b1, 32'h8000_0001, '0);
      send_word(gisc_pkg::MODE_EVENT, 9, gisc_pkg::KIND_ENABLE, 1'b1, 32'h0000_ffff, '0);
      send_word(gisc_pkg::MODE_WRITE, 9, gisc_pkg::KIND_STATUS, 1'b0, '0, 32'h8000_0001);
      send_word(gisc_pkg::MODE_WRITE, 9, gisc_pkg::KIND_STATUS, 1'b0, '0, 32'h0000_ffff);
      send_word(gisc_pkg::MODE_READ,  9, gisc_pkg::KIND_STATUS, 1'b0, '0, '0);
      send_word(gisc_pkg::MODE_READ,  0, gisc_pkg::KIND_ENABLE, 1'b0, '0, '0);
      // invalid groups in every mode, and mode three
      send_word(gisc_pkg::MODE_EVENT, 15, gisc_pkg::KIND_STATUS, 1'b1,
                gisc_pkg::ALL_ONES, gisc_pkg::ALL_ONES);
      send_word(gisc_pkg::MODE_WRITE, 10, gisc_pkg::KIND_STATUS, 1'b1,
                gisc_pkg::ALL_ONES, '0);
      send_word(gisc_pkg::MODE_READ,  15, gisc_pkg::KIND_STATUS, 1'b1,
                gisc_pkg::ALL_ONES, gisc_pkg::ALL_ONES);
      send_word(gisc_pkg::MODE_NONE,  15, gisc_pkg::KIND_STATUS, 1'b1,
                gisc_pkg::ALL_ONES, gisc_pkg::ALL_ONES);
      send_word(gisc_pkg::MODE_NONE,  0,  gisc_pkg::KIND_ENABLE, 1'b0, '0, '0);
   endtask

   task automatic test_random_flows(input int count);
      repeat (count) begin
         if ($urandom_range(99) < 20) send_noise();
         else send_flow();
      end
   endtask

   // Hold responses off while the sender keeps offering, so the input backs up.
   task automatic test_response_holdoff();
      req_gaps_on = 1'b0;
      hold_ask    = 1'b1;
      repeat (8) send_flow();
      req_gaps_on = 1'b1;
   endtask

   // Stop sending until every response is back, then resume.
   task automatic test_drain_pause();
      repeat (4) send_flow();
      wait_drained();
      repeat (4) send_flow();
   endtask

   task automatic test_steady_stream();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      repeat (12) send_flow();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // --------------------------------------------------------------------------
   // Response side
   // --------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
      mismatches++;
   endtask

   // Check each accepted response word, then pick the next stall level.
   always @(posedge clock) begin : rsp_side
      irq_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp_q.size() == 0) begin
               report_mismatch("unexpected word", rsp_read_data, '0);
            end else begin
               want = awaited_rsp_q.pop_front();
               if (rsp_irq_out !== want.irq)
                  report_mismatch("irq_out", DATA_W'(rsp_irq_out), DATA_W'(want.irq));
               if (rsp_read_data !== want.rdata)
                  report_mismatch("read_data", rsp_read_data, want.rdata);
               if (rsp_status !== want.code)
                  report_mismatch("status", DATA_W'(rsp_status), DATA_W'(want.code));
            end
         end
         if (hold_ask) begin
            hold_left = HOLD_CYCLES;
            hold_ask  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= rsp_gaps_on && ($urandom_range(99) < 23);
         end
      end
   end

   // Watchdog: end the run when no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_count <= 0;
      end else if (quiet_count >= QUIET_LIMIT) begin
         $display("grouped_interrupt_status_controller_unit_tb: errors");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   initial begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_enable_sum[g]  = '0;
         grp_enable_last[g] = '0;
         grp_status[g]      = '0;
         grp_mask[g]        = '0;
         grp_pending[g]     = '0;
      end
      irq_lines = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_flows(30);
      test_response_holdoff();
      test_random_flows(20);
      test_drain_pause();
      test_steady_stream();
      test_random_flows(15);

      // settle: drain, then let any stray word show up
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited_rsp_q.size() == 0) begin
         $display("grouped_interrupt_status_controller_unit_tb: clean");
      end else begin
         $display("grouped_interrupt_status_controller_unit_tb: errors");
      end
      $finish;
   end

endmodule
